/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the channel allocator.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CPA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define CPA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CPA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/cpa_pkg.sv */
// Package of the channel allocator: word types, status and op codes, cell link types.
// No dependencies.
package cpa_pkg;

    localparam logic OP_GET     = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_ARG    = 2'd1,
        ST_NO_ENTRY   = 2'd2,
        ST_NO_CHANNEL = 2'd3
    } status_t;

    // Request word
    typedef struct packed {
        logic       op;
        logic [3:0] module_id;
        logic [5:0] release_channel;
    } req_t;

    // Result word
    typedef struct packed {
        status_t    status;
        logic [4:0] granted_channel;
    } rsp_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic       get;
        logic       rel;
        logic [3:0] module_id;
        logic [4:0] channel;
    } cpa_cmd_t;

    // Handed from cell to cell along the chain
    typedef struct packed {
        logic       taken;
        logic       full;
        logic [4:0] chan;
    } cpa_link_t;

endpackage

/* rtl/cpa_cell.sv */
// One table entry of the channel allocator: module id and channel used-bitmap.
// Depends on cpa_pkg.
module cpa_cell #(
    parameter int CHANNELS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cpa_pkg::cpa_cmd_t cmd,
    input  cpa_pkg::cpa_link_t link_in,
    output cpa_pkg::cpa_link_t link_out
);
    import cpa_pkg::*;

    logic [3:0]          module_reg;
    logic [3:0]          module_next;
    logic [CHANNELS-1:0] used_reg;
    logic [CHANNELS-1:0] used_next;

    logic                empty;
    logic                hit;
    logic                act;
    logic                full;
    logic [4:0]          free_idx;
    logic [CHANNELS-1:0] set_mask;
    logic [CHANNELS-1:0] clr_mask;

    assign empty = (module_reg == 4'd0);
    // get stops at own entry or first empty one; release needs own entry
    assign hit   = (cmd.get && (empty || module_reg == cmd.module_id))
                || (cmd.rel && module_reg == cmd.module_id);
    assign act   = hit && !link_in.taken;
    assign full  = &used_reg;

    // lowest free channel
    always_comb
    begin
        free_idx = 5'd0;
        for (int k = CHANNELS - 1; k >= 0; k--)
        begin
            if (!used_reg[k])
            begin
                free_idx = 5'(k);
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < CHANNELS; k++)
        begin
            set_mask[k] = (free_idx == 5'(k));
            clr_mask[k] = (cmd.channel == 5'(k));
        end
    end

    always_comb
    begin
        module_next = module_reg;
        used_next   = used_reg;
        if (act && cmd.get && !full)
        begin
            used_next = used_reg | set_mask;
            if (empty)
            begin
                module_next = cmd.module_id;
            end
        end
        else if (act && cmd.rel)
        begin
            used_next = used_reg & ~clr_mask;
        end
    end

    always_comb
    begin
        if (act)
        begin
            link_out.taken = 1'b1;
            link_out.full  = full;
            link_out.chan  = free_idx;
        end
        else
        begin
            link_out = link_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            module_reg <= 4'd0;
            used_reg   <= '0;
        end
        else
        begin
            module_reg <= module_next;
            used_reg   <= used_next;
        end
    end

endmodule

/* rtl/per_module_channel_allocator.sv */
// Top level of the per-module channel allocator: request register, cell chain, result register.
// Depends on cpa_pkg, cpa_cell and assert_macros.svh.
`include "assert_macros.svh"

// Channel allocator. For each request word, the accept edge
// latches it, and the following edge runs it through the chain of entry cells
// and registers the result. busy is high for that one cycle; done pulses for
// exactly one cycle with the result word, which the receiver must take then,
// as it cannot stall. A new request may be accepted in the done cycle; a
// start while busy is ignored. A get finds the first cell holding the module
// or the first empty cell and grants its lowest free channel (new modules
// are registered only if a channel is granted). A release clears the named
// channel bit in the module's cell. Entries fill in order and are never
// freed, so the count of registered modules is implied by the non-empty
// cells.
module per_module_channel_allocator #(
    parameter int TABLE_ENTRIES       = 8,
    parameter int CHANNELS_PER_MODULE = 32,
    parameter int MODULE_END          = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  cpa_pkg::req_t req,
    output logic          busy,
    output logic          done,
    output cpa_pkg::rsp_t rsp
);
    import cpa_pkg::*;

    logic      pend_reg;
    logic      pend_next;
    logic      done_reg;
    logic      done_next;
    req_t      req_reg;
    req_t      req_next;
    rsp_t      rsp_reg;
    rsp_t      rsp_next;

    logic      bad_module;
    logic      bad_chan;
    logic      bad_arg;
    cpa_cmd_t  cmd;
    cpa_link_t links [TABLE_ENTRIES+1];

    // argument checks on the held request word
    assign bad_module = (req_reg.module_id == 4'd0)
                     || ({1'b0, req_reg.module_id} >= 5'(MODULE_END));
    assign bad_chan   = (req_reg.op == OP_RELEASE)
                     && (req_reg.release_channel >= 6'(CHANNELS_PER_MODULE));
    assign bad_arg    = bad_module || bad_chan;

    // cells act only in the working cycle of a well-formed request
    assign cmd.get       = pend_reg && !bad_arg && (req_reg.op == OP_GET);
    assign cmd.rel       = pend_reg && !bad_arg && (req_reg.op == OP_RELEASE);
    assign cmd.module_id = req_reg.module_id;
    assign cmd.channel   = req_reg.release_channel[4:0];

    assign links[0] = '0;

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        cpa_cell #(
            .CHANNELS (CHANNELS_PER_MODULE)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .link_in  (links[i]),
            .link_out (links[i+1])
        );
    end

    // result word from the chain end
    always_comb
    begin
        rsp_next.granted_channel = 5'd0;
        if (bad_arg)
        begin
            rsp_next.status = ST_BAD_ARG;
        end
        else if (!links[TABLE_ENTRIES].taken)
        begin
            rsp_next.status = ST_NO_ENTRY;
        end
        else if (req_reg.op == OP_GET && links[TABLE_ENTRIES].full)
        begin
            rsp_next.status = ST_NO_CHANNEL;
        end
        else
        begin
            rsp_next.status = ST_OK;
            if (req_reg.op == OP_GET)
            begin
                rsp_next.granted_channel = links[TABLE_ENTRIES].chan;
            end
        end
    end

    assign pend_next = start && !pend_reg;
    assign done_next = pend_reg;
    assign req_next  = (start && !pend_reg) ? req : req_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        if (pend_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign busy = pend_reg;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // checks
    `CPA_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done,
        "accepted word did not make the block busy")
    `CPA_ASSERT_NXT(a_busy_done, clk, rst_n, busy, done && !busy,
        "working cycle not followed by a single result")
    `CPA_ASSERT_IMP(a_fail_zero, clk, rst_n, done && rsp.status != ST_OK,
        rsp.granted_channel == 5'd0, "failed request carries a channel number")
    `CPA_ASSERT(a_grant_range, clk, rst_n,
        !done || ({1'b0, rsp.granted_channel} < 6'(CHANNELS_PER_MODULE)),
        "granted channel beyond the channel count")

endmodule
